@@ rtl/core/btmx_pkg.sv @@
`timescale 1ns / 1ps
// Package for the binary trie maximum-XOR core: sizes, codes and shared types.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package btmx_pkg;

  localparam int KEY_BITS  = 32;
  localparam int MAX_NODES = 8192;
  localparam int KEY_W     = 32;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // Highest next-free index at which an insert still has KEY_BITS nodes left.
  localparam logic [CNT_W-1:0] FREE_LIMIT = CNT_W'(MAX_NODES - KEY_BITS);
  localparam logic [LVL_W-1:0] TOP_LEVEL  = LVL_W'(KEY_BITS - 1);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key_value;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] max_xor;
  } result_t;

  typedef enum logic {
    OP_INSERT,
    OP_QUERY
  } op_t;

  // One decoded item as it waits between the front and the back.
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Child links of one trie node: index 0 for bit 0, index 1 for bit 1.
  typedef logic [1:0][NODE_W-1:0] links_t;

  typedef enum logic {
    BK_IDLE,
    BK_WALK
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/core/btmx_front.sv @@
`timescale 1ns / 1ps
// Front end: takes an item from the command port, decodes its kind and hands it on.
// Depends on btmx_pkg.
`default_nettype none

module btmx_front
  import btmx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire item_t   item,
  input  wire q_stat_t q_stat,
  output logic         busy,
  output logic         push,
  output job_t         push_job
);

  logic  front_valid;
  job_t  held_job;
  op_t   op_dec;
  logic  take;

  always_comb begin
    unique case (item.kind)
      KIND_INSERT: op_dec = OP_INSERT;
      KIND_QUERY:  op_dec = OP_QUERY;
      default:     op_dec = OP_INSERT;
    endcase
  end

  // The holding register frees up in the same cycle that it drains.
  assign busy     = front_valid && q_stat.full;
  assign take     = start && !busy;
  assign push     = front_valid && !q_stat.full;
  assign push_job = held_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= take || (front_valid && q_stat.full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_job.op  <= op_dec;
      held_job.key <= item.key_value;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/btmx_queue.sv @@
`timescale 1ns / 1ps
// Two-entry job queue that decouples the front end from the trie walker.
// Depends on btmx_pkg.
`default_nettype none

module btmx_queue
  import btmx_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output q_stat_t   q_stat,
  output job_t      head
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.valid = (count != 2'd0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/btmx_back.sv @@
`timescale 1ns / 1ps
// Back end: walks the trie one level per cycle through the node memory and
// produces one result per job. Depends on btmx_pkg.
`default_nettype none

module btmx_back
  import btmx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t q_stat,
  input  wire job_t    head,
  output logic         pop,
  output logic         done,
  output result_t      result
);

  // Node memory; entry 0 is never used, the root lives in flip-flops.
  links_t node_mem [MAX_NODES];

  back_state_t      state, state_next;
  op_t              op;
  logic [KEY_W-1:0] key;
  logic [LVL_W-1:0] level;
  logic [NODE_W-1:0] node, node_next;
  logic             fresh, fresh_next;
  logic [CNT_W-1:0] next_free;
  logic             has_keys;
  links_t           root_links;
  links_t           rd_data;
  logic [KEY_W-1:0] best, best_next;

  links_t           cur_links;
  links_t           new_links;
  logic             bit_val;
  logic             alloc;
  logic             mem_we;
  logic             root_we;
  logic             start_walk;
  logic             finish;
  logic             early_done;
  logic [1:0]       early_status;

  // A freshly allocated node has both links clear and is not read back.
  always_comb begin
    if (node == '0) begin
      cur_links = root_links;
    end else if (fresh) begin
      cur_links = '0;
    end else begin
      cur_links = rd_data;
    end
  end

  always_comb begin
    bit_val    = key[level];
    new_links  = cur_links;
    alloc      = 1'b0;
    best_next  = best;
    node_next  = node;
    fresh_next = 1'b0;
    if (op == OP_INSERT) begin
      if (cur_links[bit_val] == '0) begin
        alloc               = 1'b1;
        new_links[bit_val]  = next_free[NODE_W-1:0];
        node_next           = next_free[NODE_W-1:0];
        fresh_next          = 1'b1;
      end else begin
        node_next = cur_links[bit_val];
      end
    end else begin
      if (cur_links[!bit_val] != '0) begin
        best_next[level] = 1'b1;
        node_next        = cur_links[!bit_val];
      end else begin
        node_next = cur_links[bit_val];
      end
    end
  end

  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    start_walk   = 1'b0;
    finish       = 1'b0;
    early_done   = 1'b0;
    early_status = STAT_OK;
    mem_we       = 1'b0;
    root_we      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_stat.valid) begin
          pop = 1'b1;
          if (head.op == OP_INSERT && next_free > FREE_LIMIT) begin
            early_done   = 1'b1;
            early_status = STAT_FULL;
          end else if (head.op == OP_QUERY && !has_keys) begin
            early_done   = 1'b1;
            early_status = STAT_EMPTY;
          end else begin
            start_walk = 1'b1;
            state_next = BK_WALK;
          end
        end
      end
      BK_WALK: begin
        mem_we  = alloc && (node != '0);
        root_we = alloc && (node == '0);
        if (level == '0) begin
          finish     = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      next_free  <= CNT_W'(1);
      has_keys   <= 1'b0;
      root_links <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= early_done || finish;
      if (start_walk && head.op == OP_INSERT) begin
        has_keys <= 1'b1;
      end
      if (alloc && state == BK_WALK) begin
        next_free <= next_free + CNT_W'(1);
      end
      if (root_we) begin
        root_links <= new_links;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_walk) begin
      op    <= head.op;
      key   <= head.key;
      level <= TOP_LEVEL;
      node  <= '0;
      fresh <= 1'b0;
      best  <= '0;
    end else if (state == BK_WALK) begin
      level <= level - LVL_W'(1);
      node  <= node_next;
      fresh <= fresh_next;
      best  <= best_next;
    end
    if (early_done) begin
      result.status  <= early_status;
      result.max_xor <= '0;
    end else if (finish) begin
      result.status  <= STAT_OK;
      result.max_xor <= (op == OP_QUERY) ? best_next : '0;
    end
  end

  // One write and one read port; the read address is the next node of the walk.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[node] <= new_links;
    end
    rd_data <= node_mem[node_next];
  end

endmodule

`default_nettype wire

@@ rtl/core/binary_trie_max_xor_core.sv @@
`timescale 1ns / 1ps
// Top level of the binary trie maximum-XOR core: front end, job queue and walker.
// Depends on btmx_pkg, btmx_front, btmx_queue and btmx_back.
//
//   Channel   Handshake            Payload
//   --------  -------------------  ------------------------------------------
//   command   start high, busy low item   (kind, key_value)
//   result    done for one cycle   result (status, max_xor)
//
// An item is taken into a holding register, decoded and passed to a two-entry
// queue. The walker pops one job at a time. An insert or a query that walks
// the trie is popped and then walks one trie level a cycle, top level first,
// and the walker takes no new job until that walk ends; the node memory's single
// read port paces the walk. A rejected insert or a query on an empty trie
// answers in the cycle after its pop. Up to four items may be in flight.
// Reset is synchronous; it clears the root links and the stored-key flag and
// sets the free-node counter to 1. The rest of the node memory needs no
// clearing pass, since a new node reads as clear until its first visit writes it.
// The receiver cannot stall; busy rises only when the queue and the holding
// register are both full.
`default_nettype none

module binary_trie_max_xor_core
  import btmx_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire item_t item,
  output logic       busy,
  output logic       done,
  output result_t    result
);

  q_stat_t q_stat;
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;

  // Front end: accept and decode.
  btmx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .q_stat   (q_stat),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  // The queue lets the front keep taking items while a walk is under way.
  btmx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_stat   (q_stat),
    .head     (head)
  );

  // Walker with the node memory, the free-node counter and the result register.
  btmx_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/btmx_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the binary trie maximum-XOR core, bound to the top level.
// Depends on btmx_pkg and binary_trie_max_xor_core.
`default_nettype none

module btmx_checker
  import btmx_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    done,
  input wire result_t result
);

  logic [2:0] pending;

  // Items accepted whose result has not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + 3'((start && !busy) ? 1 : 0) - 3'(done ? 1 : 0);
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    done |-> pending != 3'd0)
    else $error("result delivered with no item outstanding");

  a_bounded_inflight: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more items in flight than the core can hold");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STAT_OK || result.status == STAT_EMPTY ||
              result.status == STAT_FULL))
    else $error("result carries an undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status != STAT_OK |-> result.max_xor == '0)
    else $error("rejected item returned a nonzero XOR");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind binary_trie_max_xor_core btmx_checker u_btmx_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire
